FILE: hdl/adad_pkg.sv
// shared types, constants and arithmetic helpers for the adadelta element core
// no dependencies
package adad_pkg;

  localparam int DATA_W      = 32;
  localparam int RATIO_W     = 16;
  localparam int DEN_W       = DATA_W + 1;
  localparam int RATIO_SHIFT = 30;
  localparam int QUO_W       = DEN_W + RATIO_SHIFT;
  localparam int SQRT_STEPS  = 32;
  localparam int ROOT_W      = 32;
  localparam int FRONT_STAGES = 5;
  localparam int BACK_STAGES  = 5;
  localparam int LATENCY = FRONT_STAGES + QUO_W + SQRT_STEPS + BACK_STAGES;

  localparam logic [RATIO_W-1:0] RATIO_RST = 16'd62259;
  localparam logic [DATA_W-1:0]  EPS_RST   = 32'd17;
  localparam logic [DATA_W-1:0]  DECAY_RST = 32'd0;

  typedef enum logic [1:0] {
    CFG_DECAY_RATIO  = 2'd0,
    CFG_STABILIZER   = 2'd1,
    CFG_WEIGHT_DECAY = 2'd2
  } adad_cfg_idx_t;

  // per-item values that ride along with the divider and square root
  typedef struct packed {
    logic signed [DATA_W-1:0] weight;
    logic signed [DATA_W-1:0] grad;
    logic [DATA_W-1:0]        upd_avg;
    logic [DATA_W-1:0]        step_rate;
    logic [DATA_W-1:0]        nga;
    logic                     last;
  } adad_side_t;

  function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] u;
    u = v;
    return v[DATA_W-1] ? (~u + 32'd1) : u;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_s32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) return 32'sh7fffffff;
    if (v < -48'sd2147483648) return 32'sh80000000;
    return v[DATA_W-1:0];
  endfunction

  function automatic logic [16:0] ratio_inv(input logic [RATIO_W-1:0] r);
    return 17'd65536 - {1'b0, r};
  endfunction

  // old*r + sq*(1-r), rounded, shifted down and saturated
  function automatic logic [DATA_W-1:0] avg_done(input logic [47:0] p1,
                                                input logic [56:0] p2);
    logic [56:0] s;
    logic [40:0] q;
    s = {9'd0, p1} + p2 + 57'd32768;
    q = s[56:16];
    return (|q[40:32]) ? 32'hffffffff : q[31:0];
  endfunction

endpackage

FILE: hdl/adad_front.sv
// front stages: decayed gradient, squared-gradient average, divider operands
// depends on adad_pkg
module adad_front import adad_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic signed [DATA_W-1:0] in_weight,
  input  logic signed [DATA_W-1:0] in_gradient,
  input  logic [DATA_W-1:0]        in_grad_average,
  input  logic [DATA_W-1:0]        in_update_average,
  input  logic [DATA_W-1:0]        in_step_rate,
  input  logic                     in_last,
  input  logic [RATIO_W-1:0]       cfg_ratio,
  input  logic [DATA_W-1:0]        cfg_eps,
  input  logic signed [DATA_W-1:0] cfg_decay,
  output logic                     out_valid,
  output logic [DEN_W-1:0]         out_num,
  output logic [DEN_W-1:0]         out_den,
  output adad_side_t               out_side
);

  // stage a: decay product
  logic va_r;
  logic [63:0] wdm_r, wdm_nxt;
  logic wneg_r;
  logic signed [DATA_W-1:0] a_w_r, a_grad_r;
  logic [DATA_W-1:0] a_ga_r, a_ua_r, a_lr_r;
  logic a_last_r;

  assign wdm_nxt = mag32(cfg_decay) * mag32(in_weight);

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else        va_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    wdm_r    <= wdm_nxt;
    wneg_r   <= cfg_decay[DATA_W-1] ^ in_weight[DATA_W-1];
    a_w_r    <= in_weight;
    a_grad_r <= in_gradient;
    a_ga_r   <= in_grad_average;
    a_ua_r   <= in_update_average;
    a_lr_r   <= in_step_rate;
    a_last_r <= in_last;
  end

  // stage b: decayed gradient and its square
  logic vb_r;
  logic [63:0] wdm_rnd;
  logic [38:0] dm;
  logic signed [47:0] gext, dext, gsum;
  logic signed [DATA_W-1:0] g_nxt, b_g_r, b_w_r;
  logic [63:0] gsq_nxt, gsq_r;
  logic [DATA_W-1:0] b_ga_r, b_ua_r, b_lr_r;
  logic b_last_r;

  assign wdm_rnd = wdm_r + 64'd8388608;
  assign dm      = wdm_rnd[62:24];
  assign gext    = {{16{a_grad_r[DATA_W-1]}}, a_grad_r};
  assign dext    = {9'd0, dm};
  assign gsum    = wneg_r ? (gext - dext) : (gext + dext);
  assign g_nxt   = sat_s32(gsum);
  assign gsq_nxt = mag32(g_nxt) * mag32(g_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else        vb_r <= va_r;
  end

  always_ff @(posedge clk) begin
    b_g_r    <= g_nxt;
    gsq_r    <= gsq_nxt;
    b_w_r    <= a_w_r;
    b_ga_r   <= a_ga_r;
    b_ua_r   <= a_ua_r;
    b_lr_r   <= a_lr_r;
    b_last_r <= a_last_r;
  end

  // stage c: average products
  logic vc_r;
  logic [63:0] gsq_rnd;
  logic [39:0] g2;
  logic [47:0] p1_nxt, c_p1_r;
  logic [56:0] p2_nxt, c_p2_r;
  logic signed [DATA_W-1:0] c_g_r, c_w_r;
  logic [DATA_W-1:0] c_ua_r, c_lr_r;
  logic c_last_r;

  assign gsq_rnd = gsq_r + 64'd8388608;
  assign g2      = gsq_rnd[63:24];
  assign p1_nxt  = b_ga_r * cfg_ratio;
  assign p2_nxt  = g2 * ratio_inv(cfg_ratio);

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else        vc_r <= vb_r;
  end

  always_ff @(posedge clk) begin
    c_p1_r   <= p1_nxt;
    c_p2_r   <= p2_nxt;
    c_g_r    <= b_g_r;
    c_w_r    <= b_w_r;
    c_ua_r   <= b_ua_r;
    c_lr_r   <= b_lr_r;
    c_last_r <= b_last_r;
  end

  // stage d: new squared-gradient average
  logic vd_r;
  logic [DATA_W-1:0] nga_nxt, d_nga_r;
  logic signed [DATA_W-1:0] d_g_r, d_w_r;
  logic [DATA_W-1:0] d_ua_r, d_lr_r;
  logic d_last_r;

  assign nga_nxt = avg_done(c_p1_r, c_p2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else        vd_r <= vc_r;
  end

  always_ff @(posedge clk) begin
    d_nga_r  <= nga_nxt;
    d_g_r    <= c_g_r;
    d_w_r    <= c_w_r;
    d_ua_r   <= c_ua_r;
    d_lr_r   <= c_lr_r;
    d_last_r <= c_last_r;
  end

  // stage e: numerator and denominator with eps
  logic ve_r;
  logic [DEN_W-1:0] num_nxt, den_nxt, num_r, den_r;
  adad_side_t side_nxt, side_r;

  assign num_nxt = {1'b0, d_ua_r} + {1'b0, cfg_eps};
  assign den_nxt = {1'b0, d_nga_r} + {1'b0, cfg_eps};

  always_comb begin
    side_nxt.weight    = d_w_r;
    side_nxt.grad      = d_g_r;
    side_nxt.upd_avg   = d_ua_r;
    side_nxt.step_rate = d_lr_r;
    side_nxt.nga       = d_nga_r;
    side_nxt.last      = d_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else        ve_r <= vd_r;
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    side_r <= side_nxt;
  end

  assign out_valid = ve_r;
  assign out_num   = num_r;
  assign out_den   = den_r;
  assign out_side  = side_r;

endmodule

FILE: hdl/adad_div.sv
// pipelined restoring divider, one quotient bit per stage: (num << 30) / den
// depends on adad_pkg
module adad_div import adad_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [DEN_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  adad_side_t       in_side,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output logic [DEN_W-1:0] out_den,
  output adad_side_t       out_side
);

  logic             v_s    [0:QUO_W];
  logic [DEN_W-1:0] rem_s  [0:QUO_W];
  logic [QUO_W-1:0] quo_s  [0:QUO_W];
  logic [DEN_W-1:0] num_s  [0:QUO_W];
  logic [DEN_W-1:0] den_s  [0:QUO_W];
  adad_side_t       side_s [0:QUO_W];

  assign v_s[0]    = in_valid;
  assign rem_s[0]  = '0;
  assign quo_s[0]  = '0;
  assign num_s[0]  = in_num;
  assign den_s[0]  = in_den;
  assign side_s[0] = in_side;

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [QUO_W-1:0] dvd;
    logic [DEN_W:0]   trial, diff;
    logic             ge;
    logic             v_r;
    logic [DEN_W-1:0] rem_r, num_r, den_r;
    logic [QUO_W-1:0] quo_r;
    adad_side_t       side_r;

    assign dvd   = {num_s[i], {RATIO_SHIFT{1'b0}}};
    assign trial = {rem_s[i], dvd[QUO_W-1-i]};
    assign ge    = trial >= {1'b0, den_s[i]};
    assign diff  = trial - {1'b0, den_s[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) v_r <= 1'b0;
      else        v_r <= v_s[i];
    end

    always_ff @(posedge clk) begin
      rem_r  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r  <= {quo_s[i][QUO_W-2:0], ge};
      num_r  <= num_s[i];
      den_r  <= den_s[i];
      side_r <= side_s[i];
    end

    assign v_s[i+1]    = v_r;
    assign rem_s[i+1]  = rem_r;
    assign quo_s[i+1]  = quo_r;
    assign num_s[i+1]  = num_r;
    assign den_s[i+1]  = den_r;
    assign side_s[i+1] = side_r;
  end

  assign out_valid = v_s[QUO_W];
  assign out_quo   = quo_s[QUO_W];
  assign out_den   = den_s[QUO_W];
  assign out_side  = side_s[QUO_W];

endmodule

FILE: hdl/adad_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on adad_pkg
module adad_sqrt import adad_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [QUO_W-1:0]  in_quo,
  input  logic [DEN_W-1:0]  in_den,
  input  adad_side_t        in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output adad_side_t        out_side
);

  logic        v_s    [0:SQRT_STEPS];
  logic [63:0] x_s    [0:SQRT_STEPS];
  logic [63:0] res_s  [0:SQRT_STEPS];
  adad_side_t  side_s [0:SQRT_STEPS];

  // zero denominator gives a zero ratio
  assign v_s[0]    = in_valid;
  assign x_s[0]    = (in_den == '0) ? 64'd0 : {1'b0, in_quo};
  assign res_s[0]  = '0;
  assign side_s[0] = in_side;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    logic        ge;
    logic        v_r;
    logic [63:0] x_r, res_r;
    adad_side_t  side_r;

    assign trial = res_s[i] + BIT;
    assign ge    = x_s[i] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) v_r <= 1'b0;
      else        v_r <= v_s[i];
    end

    always_ff @(posedge clk) begin
      x_r    <= ge ? (x_s[i] - trial) : x_s[i];
      res_r  <= ge ? ((res_s[i] >> 1) + BIT) : (res_s[i] >> 1);
      side_r <= side_s[i];
    end

    assign v_s[i+1]    = v_r;
    assign x_s[i+1]    = x_r;
    assign res_s[i+1]  = res_r;
    assign side_s[i+1] = side_r;
  end

  assign out_valid = v_s[SQRT_STEPS];
  assign out_root  = res_s[SQRT_STEPS][ROOT_W-1:0];
  assign out_side  = side_s[SQRT_STEPS];

endmodule

FILE: hdl/adad_back.sv
// back stages: scaled update, weight step, squared-update average, result regs
// depends on adad_pkg
module adad_back import adad_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [ROOT_W-1:0]        in_root,
  input  adad_side_t               in_side,
  input  logic [RATIO_W-1:0]       cfg_ratio,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_new_weight,
  output logic [DATA_W-1:0]        out_new_grad_average,
  output logic [DATA_W-1:0]        out_new_update_average,
  output logic                     out_row_end
);

  // stage a: |g| * ratio
  logic va_r;
  logic [63:0] up_nxt, up_r;
  adad_side_t a_side_r;

  assign up_nxt = mag32(in_side.grad) * in_root;

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else        va_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    up_r     <= up_nxt;
    a_side_r <= in_side;
  end

  // stage b: round and saturate update magnitude
  logic vb_r;
  logic [64:0] up_rnd;
  logic [49:0] um_full, um_lim;
  logic [DATA_W-1:0] um_nxt, um_r;
  adad_side_t b_side_r;

  assign up_rnd  = {1'b0, up_r} + 65'd16384;
  assign um_full = up_rnd[64:15];
  assign um_lim  = a_side_r.grad[DATA_W-1] ? 50'd2147483648 : 50'd2147483647;
  assign um_nxt  = (um_full > um_lim) ? um_lim[DATA_W-1:0] : um_full[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else        vb_r <= va_r;
  end

  always_ff @(posedge clk) begin
    um_r     <= um_nxt;
    b_side_r <= a_side_r;
  end

  // stage c: step and square products
  logic vc_r;
  logic [63:0] stp_nxt, stp_r, usq_nxt, usq_r;
  adad_side_t c_side_r;

  assign stp_nxt = um_r * b_side_r.step_rate;
  assign usq_nxt = um_r * um_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else        vc_r <= vb_r;
  end

  always_ff @(posedge clk) begin
    stp_r    <= stp_nxt;
    usq_r    <= usq_nxt;
    c_side_r <= b_side_r;
  end

  // stage d: new weight and average products
  logic vd_r;
  logic [63:0] stp_rnd, usq_rnd;
  logic [39:0] step, u2;
  logic signed [47:0] w48, s48, nw48;
  logic signed [DATA_W-1:0] nw_nxt, nw_r;
  logic [47:0] p1_nxt, p1_r;
  logic [56:0] p2_nxt, p2_r;
  logic [DATA_W-1:0] d_nga_r;
  logic d_last_r;

  assign stp_rnd = stp_r + 64'd8388608;
  assign step    = stp_rnd[63:24];
  assign usq_rnd = usq_r + 64'd8388608;
  assign u2      = usq_rnd[63:24];
  assign w48     = {{16{c_side_r.weight[DATA_W-1]}}, c_side_r.weight};
  assign s48     = {8'd0, step};
  // negative update moves the weight up
  assign nw48    = c_side_r.grad[DATA_W-1] ? (w48 + s48) : (w48 - s48);
  assign nw_nxt  = sat_s32(nw48);
  assign p1_nxt  = c_side_r.upd_avg * cfg_ratio;
  assign p2_nxt  = u2 * ratio_inv(cfg_ratio);

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else        vd_r <= vc_r;
  end

  always_ff @(posedge clk) begin
    nw_r     <= nw_nxt;
    p1_r     <= p1_nxt;
    p2_r     <= p2_nxt;
    d_nga_r  <= c_side_r.nga;
    d_last_r <= c_side_r.last;
  end

  // stage e: result registers
  logic ve_r;
  logic signed [DATA_W-1:0] e_nw_r;
  logic [DATA_W-1:0] e_nga_r, nua_nxt, e_nua_r;
  logic e_last_r;

  assign nua_nxt = avg_done(p1_r, p2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else        ve_r <= vd_r;
  end

  always_ff @(posedge clk) begin
    e_nw_r   <= nw_r;
    e_nga_r  <= d_nga_r;
    e_nua_r  <= nua_nxt;
    e_last_r <= d_last_r;
  end

  assign out_valid              = ve_r;
  assign out_new_weight         = e_nw_r;
  assign out_new_grad_average   = e_nga_r;
  assign out_new_update_average = e_nua_r;
  assign out_row_end            = e_last_r;

endmodule

FILE: hdl/adadelta_update_element_core.sv
// top level of the adadelta element update core with l2 weight decay
// depends on adad_pkg, adad_front, adad_div, adad_sqrt, adad_back
//
// channel   ports                                handshake
// input     start, busy, in_*                    taken when start && !busy
// result    out_valid, out_*                     one-cycle strobe, no back-pressure
// config    cfg_we, cfg_index, cfg_wdata         written when cfg_we
//
// fully pipelined: one item per cycle
// the pipeline is made of the divider (63 stages, one quotient bit each), the
// square root (32 stages, one root bit each), plus 5 front and 5 back stages
// busy is always low; the pipeline never stalls since results cannot be held
// synchronous reset clears all valid bits and loads the config defaults
module adadelta_update_element_core import adad_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] in_weight,
  input  logic signed [DATA_W-1:0] in_gradient,
  input  logic [DATA_W-1:0]        in_grad_average,
  input  logic [DATA_W-1:0]        in_update_average,
  input  logic [DATA_W-1:0]        in_step_rate,
  input  logic                     in_last_element,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_new_weight,
  output logic [DATA_W-1:0]        out_new_grad_average,
  output logic [DATA_W-1:0]        out_new_update_average,
  output logic                     out_row_end,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata
);

  // configuration registers
  logic [RATIO_W-1:0]       ratio_r;
  logic [DATA_W-1:0]        eps_r;
  logic signed [DATA_W-1:0] decay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= RATIO_RST;
      eps_r   <= EPS_RST;
      decay_r <= DECAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DECAY_RATIO:  ratio_r <= cfg_wdata[RATIO_W-1:0];
        CFG_STABILIZER:   eps_r   <= cfg_wdata;
        CFG_WEIGHT_DECAY: decay_r <= cfg_wdata;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // never busy: every cycle can take an item
  assign busy = 1'b0;

  logic             in_take;
  assign in_take = start && !busy;

  // front: decayed gradient, new grad average, divider operands
  logic             f_valid;
  logic [DEN_W-1:0] f_num, f_den;
  adad_side_t       f_side;

  adad_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_take),
    .in_weight         (in_weight),
    .in_gradient       (in_gradient),
    .in_grad_average   (in_grad_average),
    .in_update_average (in_update_average),
    .in_step_rate      (in_step_rate),
    .in_last           (in_last_element),
    .cfg_ratio         (ratio_r),
    .cfg_eps           (eps_r),
    .cfg_decay         (decay_r),
    .out_valid         (f_valid),
    .out_num           (f_num),
    .out_den           (f_den),
    .out_side          (f_side)
  );

  // divider: ratio squared in q.30
  logic             d_valid;
  logic [QUO_W-1:0] d_quo;
  logic [DEN_W-1:0] d_den;
  adad_side_t       d_side;

  adad_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_num    (f_num),
    .in_den    (f_den),
    .in_side   (f_side),
    .out_valid (d_valid),
    .out_quo   (d_quo),
    .out_den   (d_den),
    .out_side  (d_side)
  );

  // square root: ratio in q.15
  logic              s_valid;
  logic [ROOT_W-1:0] s_root;
  adad_side_t        s_side;

  adad_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_quo    (d_quo),
    .in_den    (d_den),
    .in_side   (d_side),
    .out_valid (s_valid),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  // back: update, weight step, new update average
  adad_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (s_valid),
    .in_root                (s_root),
    .in_side                (s_side),
    .cfg_ratio              (ratio_r),
    .out_valid              (out_valid),
    .out_new_weight         (out_new_weight),
    .out_new_grad_average   (out_new_grad_average),
    .out_new_update_average (out_new_update_average),
    .out_row_end            (out_row_end)
  );

`ifndef SYNTHESIS
  // every accepted item comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> ##LATENCY out_valid)
    else $error("item lost in pipeline");

  // no result without an item taken the fixed latency earlier
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_take, LATENCY))
    else $error("result without item");

  // row marker stays aligned with its item
  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row_end == $past(in_last_element, LATENCY)))
    else $error("row end misaligned");
`endif

endmodule
